>>> design/ber_tle_pkg.sv
// Constants and state codes for the BER tag/length header encoder.
`default_nettype none
package ber_tle_pkg;

  localparam logic [4:0] TAG_ESCAPE    = 5'h1f;
  localparam logic [7:0] LEN_LONG_FLAG = 8'h80;
  localparam logic [7:0] BYTE_MASK     = 8'hff;
  localparam int         TAG_DIGITS    = 5;
  localparam int         LEN_BYTES     = 4;
  localparam int         WORK_W        = 35;
  localparam int         CNT_W         = 3;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_TNORM = 3'd1;
  localparam logic [2:0] S_ID    = 3'd2;
  localparam logic [2:0] S_TDIG  = 3'd3;
  localparam logic [2:0] S_LNORM = 3'd4;
  localparam logic [2:0] S_LHDR  = 3'd5;
  localparam logic [2:0] S_LBYTE = 3'd6;

endpackage
`default_nettype wire

>>> design/ber_tag_length_header_encoder_unit.sv
// BER identifier and length octet encoder, top level.
//
// Usage: present an element header on the in_ ports and pulse start while
// busy is low; the header is transferred at that edge. The block then emits
// the identifier octets followed by the length octets, one per out_valid
// strobe, each shown for exactly one cycle; out_last_byte marks the final
// octet. The receiver cannot stall the block and must take every strobe.
// One shared shift unit and a small digit counter do all the work: the
// tag (7-bit digits) and then the length (8-bit bytes) pass through the
// same work register, first skipping leading zero digits, then emitting.
// Sequence: a short tag goes straight to the identifier octet (S_ID); for
// tags of 31 and above, leading zero tag digits are first skipped (S_TNORM)
// and the tag digits (S_TDIG) follow the identifier octet. Long-form lengths
// skip leading zero length bytes (S_LNORM) before the length header (S_LHDR)
// and the length bytes (S_LBYTE). busy stays high until the final
// octet is registered out; the next header may be transferred then.
// Reset (rst_n low, synchronous) returns the sequencer to idle and drops
// out_valid; a header in progress is abandoned.
`default_nettype none
module ber_tag_length_header_encoder_unit
  import ber_tle_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_tag_class,
  input  wire logic        in_constructed,
  input  wire logic [31:0] in_tag_number,
  input  wire logic [31:0] in_length_value,
  input  wire logic        in_indefinite_length,
  output logic             out_valid,
  output logic [7:0]       out_byte,
  output logic             out_last_byte
);

  logic [2:0]        state_r, state_nxt;
  logic [WORK_W-1:0] work_r, work_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [31:0]       len_r, len_nxt;
  logic [2:0]        lead_r, lead_nxt;
  logic [4:0]        tag_lo_r, tag_lo_nxt;
  logic              esc_r, esc_nxt;
  logic              indef_r, indef_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_byte_r, out_byte_nxt;
  logic              out_last_r, out_last_nxt;

  logic              len_phase;
  logic [7:0]        top_digit;
  logic              top_zero;
  logic [WORK_W-1:0] work_shift;
  logic              short_len;
  logic              long_len;
  logic              accept;

  assign accept    = start && (state_r == S_IDLE);
  assign len_phase = (state_r == S_LNORM) || (state_r == S_LHDR) || (state_r == S_LBYTE);
  assign top_digit = len_phase ? work_r[WORK_W-1 -: 8] : {1'b0, work_r[WORK_W-1 -: 7]};
  assign top_zero  = (top_digit == 8'd0);
  assign work_shift = len_phase ? (work_r << 8) : (work_r << 7);
  assign short_len = (len_r[31:7] == 25'd0);
  assign long_len  = !indef_r && !short_len;

  always_comb begin
    state_nxt     = state_r;
    work_nxt      = work_r;
    cnt_nxt       = cnt_r;
    len_nxt       = len_r;
    lead_nxt      = lead_r;
    tag_lo_nxt    = tag_lo_r;
    esc_nxt       = esc_r;
    indef_nxt     = indef_r;
    out_valid_nxt = 1'b0;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          work_nxt   = {3'b000, in_tag_number};
          cnt_nxt    = CNT_W'(TAG_DIGITS);
          len_nxt    = in_length_value;
          lead_nxt   = {in_tag_class, in_constructed};
          tag_lo_nxt = in_tag_number[4:0];
          esc_nxt    = (in_tag_number[31:5] != 27'd0) || (in_tag_number[4:0] == TAG_ESCAPE);
          indef_nxt  = in_indefinite_length;
          state_nxt  = ((in_tag_number[31:5] != 27'd0) ||
                        (in_tag_number[4:0] == TAG_ESCAPE)) ? S_TNORM : S_ID;
        end
      end
      S_TNORM: begin
        if (top_zero && (cnt_r > CNT_W'(1))) begin
          work_nxt = work_shift;
          cnt_nxt  = cnt_r - CNT_W'(1);
        end else begin
          state_nxt = S_ID;
        end
      end
      S_ID: begin
        out_valid_nxt = 1'b1;
        out_byte_nxt  = {lead_r, esc_r ? TAG_ESCAPE : tag_lo_r};
        if (esc_r) begin
          state_nxt = S_TDIG;
        end else begin
          work_nxt  = {len_r, 3'b000};
          cnt_nxt   = CNT_W'(LEN_BYTES);
          state_nxt = long_len ? S_LNORM : S_LHDR;
        end
      end
      S_TDIG: begin
        out_valid_nxt = 1'b1;
        out_byte_nxt  = {(cnt_r != CNT_W'(1)), top_digit[6:0]};
        if (cnt_r == CNT_W'(1)) begin
          work_nxt  = {len_r, 3'b000};
          cnt_nxt   = CNT_W'(LEN_BYTES);
          state_nxt = long_len ? S_LNORM : S_LHDR;
        end else begin
          work_nxt = work_shift;
          cnt_nxt  = cnt_r - CNT_W'(1);
        end
      end
      S_LNORM: begin
        if (top_zero && (cnt_r > CNT_W'(1))) begin
          work_nxt = work_shift;
          cnt_nxt  = cnt_r - CNT_W'(1);
        end else begin
          state_nxt = S_LHDR;
        end
      end
      S_LHDR: begin
        out_valid_nxt = 1'b1;
        if (indef_r) begin
          out_byte_nxt = LEN_LONG_FLAG;
          out_last_nxt = 1'b1;
          state_nxt    = S_IDLE;
        end else if (short_len) begin
          out_byte_nxt = len_r[7:0] & BYTE_MASK;
          out_last_nxt = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          out_byte_nxt = LEN_LONG_FLAG | {5'd0, cnt_r};
          state_nxt    = S_LBYTE;
        end
      end
      S_LBYTE: begin
        out_valid_nxt = 1'b1;
        out_byte_nxt  = top_digit;
        work_nxt      = work_shift;
        cnt_nxt       = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          out_last_nxt = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    work_r     <= work_nxt;
    cnt_r      <= cnt_nxt;
    len_r      <= len_nxt;
    lead_r     <= lead_nxt;
    tag_lo_r   <= tag_lo_nxt;
    esc_r      <= esc_nxt;
    indef_r    <= indef_nxt;
    out_byte_r <= out_byte_nxt;
  end

  assign busy          = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_byte      = out_byte_r;
  assign out_last_byte = out_last_r;

endmodule
`default_nettype wire
